>>> rtl/reminder_alarm_table_macros.svh
// Assertion macros for the reminder alarm table; expect clk and arst_n in scope.
`ifndef REMINDER_ALARM_TABLE_MACROS_SVH
`define REMINDER_ALARM_TABLE_MACROS_SVH

// Same-cycle implication.
`define RAT_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define RAT_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/rat_pkg.sv
// Types, constants and helpers shared by the reminder alarm table.
`timescale 1ns / 1ps
`default_nettype none

package rat_pkg;

	localparam int SLOTS       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int SEC_PER_MIN = 60;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_COMPLETE = 2'd2;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_FIRED     = 3'd1;
	localparam logic [2:0] EV_FOLLOW_UP = 3'd2;
	localparam logic [2:0] EV_ADDED     = 3'd3;
	localparam logic [2:0] EV_FULL      = 3'd4;
	localparam logic [2:0] EV_COMPLETED = 3'd5;
	localparam logic [2:0] EV_NOT_FOUND = 3'd6;

	typedef struct packed {
		logic [1:0]         operation;
		logic [31:0]        current_time;
		logic [31:0]        due_time;
		logic signed [15:0] interval_minutes;
		logic [15:0]        target_id;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] reminder_id;
		logic [3:0]  slot;
		logic [7:0]  review_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] id;
		logic        done;
		logic        fired;
		logic [31:0] due;
		logic [14:0] interval;
		logic [31:0] next_review;
		logic [7:0]  reviews;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	function automatic logic [31:0] sat_add_min(input logic [31:0] base,
			input logic [14:0] minutes);
		logic [20:0] secs;
		logic [32:0] sum;
		secs = {6'd0, minutes} * 21'(SEC_PER_MIN);
		sum  = {1'b0, base} + {12'd0, secs};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/rat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/reminder_alarm_table.sv
// Reminder alarm table: slot RAM scanned by a read-modify-write sequencer.
// Every operation sweeps all SLOTS entries through the RAM, one slot per cycle
// unless a full output stalls it; an item occupies the block until its final result.
// The final result is registered on leaving ST_FINISH; tick results stream earlier.
// Reset empties every slot through per-slot valid flops and sets the next id to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "reminder_alarm_table_macros.svh"

module reminder_alarm_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rat_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output rat_pkg::result_t  result
);

	rat_pkg::state_t               state_q;
	logic [1:0]                    op_q;
	logic [31:0]                   now_q;
	logic [31:0]                   due_q;
	logic [14:0]                   iv_q;
	logic [15:0]                   target_q;
	logic [15:0]                   id_counter_q;
	logic [rat_pkg::CNT_W-1:0]     rd_cnt_q;
	logic                          valid_s1;
	logic [rat_pkg::SLOT_W-1:0]    idx_s1;
	logic [rat_pkg::SLOTS-1:0]     vld_q;
	logic                          found_q;
	logic                          pend_v_q;
	rat_pkg::result_t              pend_q;
	logic [rat_pkg::RES_W-1:0]     res_cnt_q;
	logic                          out_v_q;
	rat_pkg::result_t              out_q;

	rat_pkg::entry_t               rd_data;
	rat_pkg::entry_t               ent;
	rat_pkg::entry_t               wr_data;
	rat_pkg::result_t              new_res;
	rat_pkg::result_t              fin_res;
	logic [31:0]                   nr_new;
	logic [2:0]                    ev_code;
	logic                          accept;
	logic                          out_free;
	logic                          out_load;
	logic                          live;
	logic                          fire;
	logic                          follow;
	logic                          hit;
	logic                          report;
	logic                          proc_ok;
	logic                          advance;
	logic                          issue;
	logic                          wr_en;
	logic [rat_pkg::SLOT_W-1:0]    rd_addr;

	assign item_stall   = (state_q != rat_pkg::ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign out_free     = !out_v_q || !result_stall;
	assign result_valid = out_v_q;
	assign result       = out_q;

	always_comb begin
		ent = rd_data;
		if (!vld_q[idx_s1]) begin
			ent.id    = '0;
			ent.done  = 1'b0;
			ent.fired = 1'b0;
		end
	end

	assign live   = (ent.id != '0) && !ent.done;
	assign fire   = live && !ent.fired && (ent.due != '0) && (now_q >= ent.due);
	assign follow = live && ent.fired && (ent.interval != '0) &&
		(ent.next_review != '0) && (now_q >= ent.next_review);
	assign nr_new = rat_pkg::sat_add_min(fire ? ent.due : now_q, ent.interval);

	always_comb begin
		wr_data = ent;
		hit     = 1'b0;
		ev_code = rat_pkg::EV_NONE;
		unique case (op_q)
			rat_pkg::OP_TICK: begin
				if (fire) begin
					wr_data.fired   = 1'b1;
					wr_data.reviews = '0;
					if (ent.interval != '0) begin
						wr_data.next_review = nr_new;
					end
					hit     = 1'b1;
					ev_code = rat_pkg::EV_FIRED;
				end else if (follow) begin
					if (ent.reviews != 8'hFF) begin
						wr_data.reviews = ent.reviews + 8'd1;
					end
					wr_data.next_review = nr_new;
					hit     = 1'b1;
					ev_code = rat_pkg::EV_FOLLOW_UP;
				end
			end
			rat_pkg::OP_ADD: begin
				if (!found_q && ent.id == '0) begin
					wr_data.id          = id_counter_q;
					wr_data.done        = 1'b0;
					wr_data.fired       = 1'b0;
					wr_data.due         = due_q;
					wr_data.interval    = iv_q;
					wr_data.next_review = '0;
					wr_data.reviews     = '0;
					hit     = 1'b1;
					ev_code = rat_pkg::EV_ADDED;
				end
			end
			rat_pkg::OP_COMPLETE: begin
				if (!found_q && target_q != '0 && ent.id == target_q) begin
					wr_data.done        = 1'b1;
					wr_data.fired       = 1'b0;
					wr_data.next_review = '0;
					wr_data.reviews     = '0;
					hit     = 1'b1;
					ev_code = rat_pkg::EV_COMPLETED;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		new_res              = '0;
		new_res.event_res    = ev_code;
		new_res.reminder_id  = wr_data.id;
		new_res.slot         = 4'(idx_s1);
		new_res.review_count = wr_data.reviews;
	end

	always_comb begin
		fin_res = '0;
		if (pend_v_q) begin
			fin_res = pend_q;
		end else begin
			unique case (op_q)
				rat_pkg::OP_ADD:      fin_res.event_res = rat_pkg::EV_FULL;
				rat_pkg::OP_COMPLETE: begin
					fin_res.event_res   = rat_pkg::EV_NOT_FOUND;
					fin_res.reminder_id = target_q;
				end
				default:              fin_res.event_res = rat_pkg::EV_NONE;
			endcase
		end
		fin_res.last = 1'b1;
	end

	assign report  = hit && (res_cnt_q != rat_pkg::RES_W'(rat_pkg::MAX_RESULTS));
	assign proc_ok = !(valid_s1 && report && pend_v_q && !out_free);
	assign advance = valid_s1 && proc_ok;
	assign wr_en   = advance && hit;
	assign issue   = (state_q == rat_pkg::ST_SCAN) &&
		(rd_cnt_q < rat_pkg::CNT_W'(rat_pkg::SLOTS)) && proc_ok;
	assign rd_addr = rd_cnt_q[rat_pkg::SLOT_W-1:0];
	assign out_load = ((state_q == rat_pkg::ST_SCAN) && advance && report && pend_v_q) ||
		((state_q == rat_pkg::ST_FINISH) && out_free);

	rat_ram #(
		.WIDTH($bits(rat_pkg::entry_t)),
		.DEPTH(rat_pkg::SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rat_pkg::ST_IDLE;
			id_counter_q <= 16'd1;
			rd_cnt_q     <= '0;
			valid_s1     <= 1'b0;
			vld_q        <= '0;
			found_q      <= 1'b0;
			pend_v_q     <= 1'b0;
			res_cnt_q    <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				rat_pkg::ST_IDLE: begin
					if (accept) begin
						rd_cnt_q  <= '0;
						found_q   <= 1'b0;
						pend_v_q  <= 1'b0;
						res_cnt_q <= '0;
						state_q   <= rat_pkg::ST_SCAN;
					end
				end
				rat_pkg::ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
						valid_s1 <= 1'b1;
					end else if (advance) begin
						valid_s1 <= 1'b0;
					end
					if (wr_en) begin
						found_q        <= 1'b1;
						vld_q[idx_s1]  <= 1'b1;
						if (op_q == rat_pkg::OP_ADD) begin
							id_counter_q <= (id_counter_q == 16'hFFFF) ? 16'd1 :
								id_counter_q + 16'd1;
						end
					end
					if (advance && report) begin
						res_cnt_q <= res_cnt_q + 1'b1;
						pend_v_q  <= 1'b1;
					end
					if (rd_cnt_q == rat_pkg::CNT_W'(rat_pkg::SLOTS) && !valid_s1) begin
						state_q <= rat_pkg::ST_FINISH;
					end
				end
				rat_pkg::ST_FINISH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= rat_pkg::ST_IDLE;
					end
				end
				default: state_q <= rat_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= item.operation;
			now_q    <= item.current_time;
			due_q    <= item.due_time;
			iv_q     <= item.interval_minutes[15] ? 15'd0 : item.interval_minutes[14:0];
			target_q <= item.target_id;
		end
		if (issue) begin
			idx_s1 <= rd_addr;
		end
		if (state_q == rat_pkg::ST_SCAN && advance && report) begin
			pend_q <= new_res;
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end
		if (state_q == rat_pkg::ST_FINISH && out_free) begin
			out_q <= fin_res;
		end
	end

	`RAT_ASSERT_IMP(a_idle_no_write, state_q == rat_pkg::ST_IDLE, !wr_en, "RAM write while idle")
	`RAT_ASSERT_IMP(a_s1_in_scan, valid_s1, state_q == rat_pkg::ST_SCAN, "read stage outside scan")
	`RAT_ASSERT_IMP(a_idle_no_pend, state_q == rat_pkg::ST_IDLE, !pend_v_q,
		"pending result left over")
	`RAT_ASSERT_IMP(a_none_is_last, out_v_q && out_q.event_res == rat_pkg::EV_NONE,
		out_q.last, "none result not last")
	`RAT_ASSERT_NEXT(a_one_add_write, wr_en && op_q == rat_pkg::OP_ADD, !wr_en,
		"second write in one add")
	`RAT_ASSERT_IMP(a_rd_cnt_bound, 1'b1, rd_cnt_q <= rat_pkg::CNT_W'(rat_pkg::SLOTS),
		"read count overrun")

endmodule

`default_nettype wire
